// ----- src/sbb_pkg.sv -----
// Package for the separable 3x3 binomial blur: sizes, register indexes, the job record
// passed from the horizontal to the vertical pass, and the fixed-point filter functions.
// No dependencies.
`default_nettype none

package sbb_pkg;

	// Frame and sample limits.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int PIXEL_BITS = 16;
	localparam int HFRAC      = 4;

	localparam int COL_BITS = $clog2(MAX_WIDTH);
	localparam int ROW_BITS = $clog2(MAX_HEIGHT);
	localparam int H_BITS   = PIXEL_BITS + HFRAC;

	// Configuration port.
	localparam int WIDTH_REG_BITS  = 11;
	localparam int HEIGHT_REG_BITS = 13;
	localparam int CFG_DATA_BITS   = 13;
	localparam int CFG_INDEX_BITS  = 2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_BITS'(1);

	// Divide by three through a reciprocal multiply, exact for all inputs below 2**DIV_IN_BITS.
	localparam int DIV_IN_BITS = H_BITS + 4;
	localparam int DIV3_SHIFT  = DIV_IN_BITS + 2;
	localparam int PROD_BITS   = DIV_IN_BITS + DIV3_SHIFT - 1;
	localparam longint unsigned DIV3_MUL = ((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3;

	localparam logic [PIXEL_BITS-1:0] PIX_MAX = '1;

	// One horizontal result on its way to the vertical pass.
	typedef struct packed {
		logic [COL_BITS-1:0] x;
		logic [H_BITS-1:0]   h;
		logic [ROW_BITS-1:0] row;
		logic                emit_main;
		logic                main_edge;
		logic                emit_last;
		logic                done;
		logic                last_job;
	} hjob_t;

	function automatic logic [DIV_IN_BITS-1:0] div3(input logic [DIV_IN_BITS-1:0] n);
		logic [PROD_BITS-1:0] prod;
		prod = PROD_BITS'(n) * PROD_BITS'(DIV3_MUL);
		return DIV_IN_BITS'(prod >> DIV3_SHIFT);
	endfunction

	// Edge tap [2 1]/3 with HFRAC fraction bits, rounded half up.
	function automatic logic [H_BITS-1:0] horiz_edge(input logic [PIXEL_BITS-1:0] centre,
			input logic [PIXEL_BITS-1:0] side);
		logic [PIXEL_BITS+1:0]    s;
		logic [DIV_IN_BITS-1:0]   n;
		logic [DIV_IN_BITS-1:0]   q;
		s = {1'b0, centre, 1'b0} + {2'b00, side};
		n = (DIV_IN_BITS'(s) << HFRAC) + DIV_IN_BITS'(1);
		q = div3(n);
		return q[H_BITS-1:0];
	endfunction

	// Interior taps [1 2 1]/4 with HFRAC fraction bits, exact.
	function automatic logic [H_BITS-1:0] horiz_mid(input logic [PIXEL_BITS-1:0] a,
			input logic [PIXEL_BITS-1:0] b, input logic [PIXEL_BITS-1:0] c);
		logic [PIXEL_BITS+1:0] s;
		s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
		return H_BITS'(s) << (HFRAC - 2);
	endfunction

	// Vertical edge tap [2 1]/3, rounded half up to the pixel format and saturated.
	function automatic logic [PIXEL_BITS-1:0] vert_edge(input logic [H_BITS-1:0] centre,
			input logic [H_BITS-1:0] side);
		logic [H_BITS+2:0]      t;
		logic [DIV_IN_BITS-1:0] q;
		t = {2'b00, centre, 1'b0} + {3'b000, side} + (H_BITS+3)'(3 << (HFRAC - 1));
		q = div3(DIV_IN_BITS'(t >> HFRAC));
		return (q > DIV_IN_BITS'(PIX_MAX)) ? PIX_MAX : q[PIXEL_BITS-1:0];
	endfunction

	// Vertical interior taps [1 2 1]/4, rounded half up and saturated.
	function automatic logic [PIXEL_BITS-1:0] vert_mid(input logic [H_BITS-1:0] a,
			input logic [H_BITS-1:0] b, input logic [H_BITS-1:0] c);
		logic [H_BITS+2:0]   t;
		logic [PIXEL_BITS:0] v;
		t = {3'b000, a} + {2'b00, b, 1'b0} + {3'b000, c} + (H_BITS+3)'(1 << (HFRAC + 1));
		v = (PIXEL_BITS+1)'(t >> (HFRAC + 2));
		return v[PIXEL_BITS] ? PIX_MAX : v[PIXEL_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- src/sbb_if.sv -----
// Stream interfaces of the blur: the pixel input channel and the result channel.
// Depends on sbb_pkg for field widths.
`default_nettype none

interface sbb_pix_in_if import sbb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

interface sbb_pix_out_if import sbb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel_out;
	logic [COL_BITS-1:0]   out_col;
	logic [ROW_BITS-1:0]   out_row;
	logic                  frame_done;
	logic                  last_of_run;

	modport source (output valid, output pixel_out, output out_col, output out_row,
		output frame_done, output last_of_run, input ready);
	modport sink (input valid, input pixel_out, input out_col, input out_row,
		input frame_done, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- src/sbb_hpass.sv -----
// Horizontal pass: frame registers, raster position, input register and the [1 2 1]
// row filter. Issues up to two horizontal results per pixel. Depends on sbb_pkg, sbb_if.
`default_nettype none

module sbb_hpass import sbb_pkg::*; (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_wr_en,
	input  wire [CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire [CFG_DATA_BITS-1:0]    cfg_wdata,
	sbb_pix_in_if.sink                 pixels,
	output hjob_t                      job,
	output logic                       job_valid,
	input  wire                        job_ready
);

	logic [COL_BITS-1:0]   wlast_q;
	logic [ROW_BITS-1:0]   hlast_q;
	logic [COL_BITS-1:0]   col_q;
	logic [ROW_BITS-1:0]   row_q;
	logic [PIXEL_BITS-1:0] prev1_q;
	logic [PIXEL_BITS-1:0] prev2_q;

	logic [PIXEL_BITS-1:0] pix_s1;
	logic [PIXEL_BITS-1:0] prev1_s1;
	logic [PIXEL_BITS-1:0] prev2_s1;
	logic [COL_BITS-1:0]   col_s1;
	logic [ROW_BITS-1:0]   row_s1;
	logic                  pend_a_s1;
	logic                  pend_b_s1;

	logic [WIDTH_REG_BITS-1:0]  w_raw;
	logic [HEIGHT_REG_BITS-1:0] h_raw;
	logic [COL_BITS-1:0]        wlast_new;
	logic [ROW_BITS-1:0]        hlast_new;
	logic                       cfg_restart;
	logic [COL_BITS-1:0]        col_eff;
	logic [ROW_BITS-1:0]        row_eff;
	logic                       accept;
	logic                       issue;
	logic                       issue_last;

	// Clamp written frame sizes to the supported range.
	always_comb begin
		w_raw = cfg_wdata[WIDTH_REG_BITS-1:0];
		h_raw = cfg_wdata[HEIGHT_REG_BITS-1:0];
		if (w_raw < WIDTH_REG_BITS'(2)) begin
			wlast_new = COL_BITS'(1);
		end else if (w_raw > WIDTH_REG_BITS'(MAX_WIDTH)) begin
			wlast_new = COL_BITS'(MAX_WIDTH - 1);
		end else begin
			wlast_new = COL_BITS'(w_raw - WIDTH_REG_BITS'(1));
		end
		if (h_raw < HEIGHT_REG_BITS'(2)) begin
			hlast_new = ROW_BITS'(1);
		end else if (h_raw > HEIGHT_REG_BITS'(MAX_HEIGHT)) begin
			hlast_new = ROW_BITS'(MAX_HEIGHT - 1);
		end else begin
			hlast_new = ROW_BITS'(h_raw - HEIGHT_REG_BITS'(1));
		end
	end

	assign cfg_restart = cfg_wr_en &&
		(cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

	// Frame size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= COL_BITS'(MAX_WIDTH - 1);
			hlast_q <= ROW_BITS'(MAX_HEIGHT - 1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  wlast_q <= wlast_new;
				REG_IMAGE_HEIGHT: hlast_q <= hlast_new;
				default: ;
			endcase
		end
	end

	// Handshakes: a new pixel enters once the last pending job of the held pixel leaves.
	assign job_valid    = pend_a_s1 | pend_b_s1;
	assign issue        = job_valid && job_ready;
	assign issue_last   = issue && !(pend_a_s1 && pend_b_s1);
	assign pixels.ready = !job_valid || issue_last;
	assign accept       = pixels.valid && pixels.ready;

	assign col_eff = (col_q > wlast_q) ? wlast_q : col_q;
	assign row_eff = (row_q > hlast_q) ? hlast_q : row_q;

	// Raster position and the two previous pixels of the row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			prev1_q <= '0;
			prev2_q <= '0;
		end else if (cfg_restart) begin
			col_q   <= '0;
			row_q   <= '0;
			prev1_q <= '0;
			prev2_q <= '0;
		end else if (accept) begin
			if (col_eff == wlast_q) begin
				col_q   <= '0;
				row_q   <= (row_eff == hlast_q) ? '0 : row_eff + ROW_BITS'(1);
				prev1_q <= '0;
				prev2_q <= '0;
			end else begin
				col_q   <= col_eff + COL_BITS'(1);
				prev1_q <= pixels.pixel_in;
				prev2_q <= prev1_q;
			end
		end
	end

	// Pending jobs of the held pixel: the column to the left, and at row end its own column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_a_s1 <= 1'b0;
			pend_b_s1 <= 1'b0;
		end else if (accept) begin
			pend_a_s1 <= (col_eff != '0);
			pend_b_s1 <= (col_eff == wlast_q);
		end else if (issue) begin
			if (pend_a_s1) begin
				pend_a_s1 <= 1'b0;
			end else begin
				pend_b_s1 <= 1'b0;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1   <= pixels.pixel_in;
			prev1_s1 <= prev1_q;
			prev2_s1 <= prev2_q;
			col_s1   <= col_eff;
			row_s1   <= row_eff;
		end
	end

	// Horizontal filter for the job being issued, plus its vertical-pass flags.
	always_comb begin
		if (pend_a_s1) begin
			job.x = col_s1 - COL_BITS'(1);
			job.h = (col_s1 == COL_BITS'(1)) ? horiz_edge(prev1_s1, pix_s1)
				: horiz_mid(prev2_s1, prev1_s1, pix_s1);
		end else begin
			job.x = col_s1;
			job.h = horiz_edge(pix_s1, prev1_s1);
		end
		job.row       = row_s1;
		job.emit_main = (row_s1 != '0);
		job.main_edge = (row_s1 == ROW_BITS'(1));
		job.emit_last = (row_s1 == hlast_q);
		job.done      = (job.x == wlast_q);
		job.last_job  = !(pend_a_s1 && pend_b_s1);
	end

endmodule

`default_nettype wire

// ----- src/sbb_vpass.sv -----
// Vertical pass: the two line stores, the job register with its line reads, the [1 2 1]
// column filter and the result register. Depends on sbb_pkg and sbb_if.
`default_nettype none

module sbb_vpass import sbb_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  hjob_t            job,
	input  wire              job_valid,
	output logic             job_ready,
	sbb_pix_out_if.source    results
);

	logic [H_BITS-1:0] newer_mem [MAX_WIDTH];
	logic [H_BITS-1:0] older_mem [MAX_WIDTH];

	hjob_t             job_s2;
	logic              valid_s2;
	logic              phase_s2;
	logic [H_BITS-1:0] newer_s2;
	logic [H_BITS-1:0] older_s2;

	logic                  out_valid_q;
	logic [PIXEL_BITS-1:0] out_pixel_q;
	logic [COL_BITS-1:0]   out_col_q;
	logic [ROW_BITS-1:0]   out_row_q;
	logic                  out_done_q;
	logic                  out_last_q;

	logic                  load;
	logic                  out_free;
	logic                  fire;
	logic                  final_emit;
	logic                  s2_done;
	logic [PIXEL_BITS-1:0] res_pixel;
	logic [ROW_BITS-1:0]   res_row;
	logic                  res_done;

	// A job holds the register until all its results have gone out.
	assign out_free   = !out_valid_q || results.ready;
	assign final_emit = phase_s2 || !job_s2.emit_last;
	assign fire       = valid_s2 && job_s2.emit_main && out_free;
	assign s2_done    = valid_s2 && (!job_s2.emit_main || (fire && final_emit));
	assign job_ready  = !valid_s2 || s2_done;
	assign load       = job_valid && job_ready;

	// Newer line store: read the previous row, write the new horizontal result.
	always_ff @(posedge clk) begin
		if (load) begin
			newer_s2           <= newer_mem[job.x];
			newer_mem[job.x]   <= job.h;
		end
	end

	// Older line store: read at issue, refreshed from the newer row while the job is held.
	always_ff @(posedge clk) begin
		if (load) begin
			older_s2 <= older_mem[job.x];
		end
		if (valid_s2) begin
			older_mem[job_s2.x] <= newer_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_s2 <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			phase_s2 <= 1'b0;
		end else begin
			if (load) begin
				valid_s2 <= 1'b1;
			end else if (s2_done) begin
				valid_s2 <= 1'b0;
			end
			if (load) begin
				phase_s2 <= 1'b0;
			end else if (fire && !final_emit) begin
				phase_s2 <= 1'b1;
			end
		end
	end

	// Column filter: the row above first, then on the last row the row itself.
	always_comb begin
		if (phase_s2) begin
			res_pixel = vert_edge(job_s2.h, newer_s2);
			res_row   = job_s2.row;
			res_done  = job_s2.done;
		end else begin
			res_pixel = job_s2.main_edge ? vert_edge(newer_s2, job_s2.h)
				: vert_mid(older_s2, newer_s2, job_s2.h);
			res_row   = job_s2.row - ROW_BITS'(1);
			res_done  = 1'b0;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_pixel_q <= res_pixel;
			out_col_q   <= job_s2.x;
			out_row_q   <= res_row;
			out_done_q  <= res_done;
			out_last_q  <= job_s2.last_job && final_emit;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.pixel_out   = out_pixel_q;
	assign results.out_col     = out_col_q;
	assign results.out_row     = out_row_q;
	assign results.frame_done  = out_done_q;
	assign results.last_of_run = out_last_q;

endmodule

`default_nettype wire

// ----- src/separable_binomial_blur_3x3.sv -----
// Top level of the separable 3x3 binomial blur: horizontal pass feeding vertical pass.
// Depends on sbb_pkg, sbb_if, sbb_hpass and sbb_vpass.
//
// Pixels enter in raster order on the pixels channel; filtered pixels leave on the
// results channel tagged with column and row, one row behind the input, and on the
// last row both remaining rows leave together. Each pixel but the first of a row
// yields one horizontal result, two at the end of a row; the vertical pass handles one
// horizontal result per cycle while the output does not stall, except on the last row,
// with a single line-store read port per store and one result register. On the last
// row each horizontal result yields two filtered pixels through the one result
// register, so it stays in the job register until both have entered it. Writing either
// frame register restarts the frame at row 0, column 0; write only while the block is
// idle. Widths and heights outside 2..1024 and 2..4096 are clamped. No clearing pass
// follows reset.
`default_nettype none

module separable_binomial_blur_3x3 import sbb_pkg::*; (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_wr_en,
	input  wire [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire [CFG_DATA_BITS-1:0]  cfg_wdata,
	sbb_pix_in_if.sink               pixels,
	sbb_pix_out_if.source            results
);

	hjob_t job;
	logic  job_valid;
	logic  job_ready;

	// Row filter, raster position and frame registers.
	sbb_hpass u_hpass (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pixels    (pixels),
		.job       (job),
		.job_valid (job_valid),
		.job_ready (job_ready)
	);

	// Line stores, column filter and result register.
	sbb_vpass u_vpass (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.results   (results)
	);

endmodule

`default_nettype wire
